// ===== hdl/icg_pkg.sv =====
// Shared types, constants and colour-table helpers for the iteration colour gradient.
package icg_pkg;

    localparam int CNT_W  = 16;
    localparam int PROD_W = 20;
    localparam int CH_N   = 3;
    localparam int NIB_W  = 4;
    localparam int PTS_N  = 5;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [PROD_W-1:0] prod_t;
    typedef logic [NIB_W-1:0]  nib_t;
    typedef logic [1:0]        seg_t;
    typedef logic [2:0]        pt_idx_t;
    typedef logic [NIB_W:0]    delta_t;

    typedef prod_t [CH_N-1:0] prod_vec_t;
    typedef nib_t  [CH_N-1:0] nib_vec_t;

    typedef struct packed {
        logic black;
        seg_t seg;
    } icg_side_t;

    // Register map: value of paddr[ADDR_W-1] selecting each register
    localparam logic ADDR_MAX_ITER = 1'b0;

    localparam int   RESET_MAX_ITER_INT = 1000;
    localparam cnt_t RESET_MAX_ITER = cnt_t'(RESET_MAX_ITER_INT);
    localparam cnt_t RESET_POS1     = cnt_t'(16 * RESET_MAX_ITER_INT / 100);
    localparam cnt_t RESET_POS2     = cnt_t'(42 * RESET_MAX_ITER_INT / 100);
    localparam cnt_t RESET_POS3     = cnt_t'(64 * RESET_MAX_ITER_INT / 100);

    // floor(n / 100) = (n * RECIP_100) >> RECIP_SHIFT, exact for n < 2**22
    localparam int          RECIP_SHIFT = 30;
    localparam int          RECIP_W     = 24;
    localparam int          SCALED_W    = 22;
    localparam int          MUL_W       = SCALED_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(10737419);

    // Channel 0 red, 1 green, 2 blue
    localparam nib_t PTS [CH_N][PTS_N] = '{
        '{4'd0, 4'd2,  4'd14, 4'd15, 4'd0},
        '{4'd0, 4'd6,  4'd15, 4'd10, 4'd0},
        '{4'd6, 4'd12, 4'd15, 4'd0,  4'd0}
    };

    function automatic delta_t seg_delta(input int ch, input seg_t seg);
        pt_idx_t lo;
        pt_idx_t hi;
        lo = pt_idx_t'(seg);
        hi = pt_idx_t'(seg) + pt_idx_t'(1);
        return {1'b0, PTS[ch][hi]} - {1'b0, PTS[ch][lo]};
    endfunction

    function automatic nib_t delta_mag(input int ch, input seg_t seg);
        delta_t d;
        delta_t a;
        d = seg_delta(ch, seg);
        a = d[NIB_W] ? (~d + delta_t'(1)) : d;
        return a[NIB_W-1:0];
    endfunction

    function automatic nib_t channel_value(input int ch, input seg_t seg, input nib_t q);
        delta_t d;
        nib_t   base;
        d    = seg_delta(ch, seg);
        base = PTS[ch][pt_idx_t'(seg)];
        return d[NIB_W] ? (base - q) : (base + q);
    endfunction

    // One restoring step: {quotient bit, new remainder}
    function automatic logic [PROD_W:0] div_step(input prod_t rem, input prod_t dsh);
        if (rem >= dsh)
        begin
            return {1'b1, rem - dsh};
        end
        return {1'b0, rem};
    endfunction

endpackage

// ===== hdl/iteration_color_gradient.sv =====
// Top level: maps an escape-iteration count to a packed RGB444 colour.
// A beat goes through the stage 1, 2, 3, divider and output registers to pixel_valid.
// Throughput: one beat per cycle unless pixel_stall holds it; six register stages.
// The configuration write recomputes the segment positions in the same cycle.
// Reset empties the pipeline and loads max_iterations = 1000.
module iteration_color_gradient (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [icg_pkg::ADDR_W-1:0] paddr,
    input  logic [icg_pkg::DATA_W-1:0] pwdata,
    output logic [icg_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    input  logic                       iter_valid,
    output logic                       iter_stall,
    input  icg_pkg::cnt_t              iteration_count,
    output logic                       pixel_valid,
    input  logic                       pixel_stall,
    output logic [11:0]                pixel_rgb
);
    import icg_pkg::*;

    // configuration
    cnt_t                max_iter_reg;
    cnt_t                pos1_reg;
    cnt_t                pos2_reg;
    cnt_t                pos3_reg;
    cnt_t                pos1_next;
    cnt_t                pos2_next;
    cnt_t                pos3_next;
    cnt_t                m_new;
    logic                cfg_wr;
    logic [SCALED_W-1:0] n1;
    logic [SCALED_W-1:0] n2;
    logic [SCALED_W-1:0] n3;
    logic [MUL_W-1:0]    p1;
    logic [MUL_W-1:0]    p2;
    logic [MUL_W-1:0]    p3;

    // pipeline
    logic       v1_reg;
    cnt_t       k1_reg;
    logic       en1;
    logic       ge1;
    logic       ge2;
    logic       ge3;
    icg_side_t  side1;
    cnt_t       lo1;
    cnt_t       hi1;

    logic       v2_reg;
    cnt_t       off2_reg;
    cnt_t       rng2_reg;
    icg_side_t  side2_reg;
    logic       en2;
    prod_vec_t  prod_next;

    logic       v3_reg;
    prod_vec_t  prod3_reg;
    cnt_t       rng3_reg;
    icg_side_t  side3_reg;
    logic       en3;

    logic       div_in_stall;
    logic       div_out_valid;
    nib_vec_t   div_quot;
    icg_side_t  div_side;

    logic       pixel_valid_reg;
    logic [11:0] pixel_rgb_reg;
    logic [11:0] rgb_next;
    logic       en_o;

    // register write and position update
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[ADDR_W-1] == ADDR_MAX_ITER);
    assign m_new  = pwdata[CNT_W-1:0];
    assign n1     = SCALED_W'({m_new, 4'b0000});
    assign n2     = SCALED_W'(m_new) * SCALED_W'(42);
    assign n3     = SCALED_W'({m_new, 6'b000000});
    assign p1     = MUL_W'(n1) * MUL_W'(RECIP_100);
    assign p2     = MUL_W'(n2) * MUL_W'(RECIP_100);
    assign p3     = MUL_W'(n3) * MUL_W'(RECIP_100);
    assign pos1_next = p1[RECIP_SHIFT +: CNT_W];
    assign pos2_next = p2[RECIP_SHIFT +: CNT_W];
    assign pos3_next = p3[RECIP_SHIFT +: CNT_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter_reg <= RESET_MAX_ITER;
            pos1_reg     <= RESET_POS1;
            pos2_reg     <= RESET_POS2;
            pos3_reg     <= RESET_POS3;
        end
        else if (cfg_wr)
        begin
            max_iter_reg <= m_new;
            pos1_reg     <= pos1_next;
            pos2_reg     <= pos2_next;
            pos3_reg     <= pos3_next;
        end
    end

    assign prdata = (paddr[ADDR_W-1] == ADDR_MAX_ITER) ? DATA_W'(max_iter_reg) : '0;

    // stall chain, back to front
    assign en_o       = !pixel_valid_reg || !pixel_stall;
    assign en3        = !v3_reg || !div_in_stall;
    assign en2        = !v2_reg || en3;
    assign en1        = !v1_reg || en2;
    assign iter_stall = !en1;

    // stage 1: segment search
    assign ge1 = k1_reg >= pos1_reg;
    assign ge2 = k1_reg >= pos2_reg;
    assign ge3 = k1_reg >= pos3_reg;

    always_comb
    begin
        side1.black = k1_reg >= max_iter_reg;
        if (ge3)
        begin
            side1.seg = 2'd3;
            lo1       = pos3_reg;
            hi1       = max_iter_reg;
        end
        else if (ge2)
        begin
            side1.seg = 2'd2;
            lo1       = pos2_reg;
            hi1       = pos3_reg;
        end
        else if (ge1)
        begin
            side1.seg = 2'd1;
            lo1       = pos1_reg;
            hi1       = pos2_reg;
        end
        else
        begin
            side1.seg = 2'd0;
            lo1       = '0;
            hi1       = pos1_reg;
        end
    end

    // stage 2: offset times slope magnitude
    always_comb
    begin
        for (int c = 0; c < CH_N; c++)
        begin
            prod_next[c] = prod_t'(off2_reg) * prod_t'(delta_mag(c, side2_reg.seg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
            v3_reg          <= 1'b0;
            pixel_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= iter_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en_o)
            begin
                pixel_valid_reg <= div_out_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && iter_valid)
        begin
            k1_reg <= iteration_count;
        end
        if (en2 && v1_reg)
        begin
            off2_reg  <= k1_reg - lo1;
            rng2_reg  <= hi1 - lo1;
            side2_reg <= side1;
        end
        if (en3 && v2_reg)
        begin
            prod3_reg <= prod_next;
            rng3_reg  <= rng2_reg;
            side3_reg <= side2_reg;
        end
        if (en_o && div_out_valid)
        begin
            pixel_rgb_reg <= rgb_next;
        end
    end

    icg_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3_reg),
        .in_stall  (div_in_stall),
        .dividend  (prod3_reg),
        .divisor   (rng3_reg),
        .side_in   (side3_reg),
        .out_valid (div_out_valid),
        .out_stall (!en_o),
        .quot      (div_quot),
        .side_out  (div_side)
    );

    // output: base plus or minus quotient, black at or above the limit
    always_comb
    begin
        rgb_next = '0;
        for (int c = 0; c < CH_N; c++)
        begin
            rgb_next[(CH_N-1-c)*NIB_W +: NIB_W] = channel_value(c, div_side.seg, div_quot[c]);
        end
        if (div_side.black)
        begin
            rgb_next = '0;
        end
    end

    assign pixel_valid = pixel_valid_reg;
    assign pixel_rgb   = pixel_rgb_reg;

    a_pos_order: assert property (@(posedge clk) disable iff (!rst_n)
        (pos1_reg <= pos2_reg) && (pos2_reg <= pos3_reg) && (pos3_reg <= max_iter_reg))
        else $error("segment positions out of order");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && !en1) |=> v1_reg)
        else $error("stage 1 beat lost while blocked");

    a_div_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (div_out_valid && !en_o) |=> (div_out_valid && $stable(div_quot)))
        else $error("divider result lost while output blocked");

endmodule

// ===== hdl/icg_div.sv =====
// Two-stage restoring divider giving a 4-bit quotient per colour channel.
module icg_div (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  icg_pkg::prod_vec_t dividend,
    input  icg_pkg::cnt_t     divisor,
    input  icg_pkg::icg_side_t side_in,
    output logic              out_valid,
    input  logic              out_stall,
    output icg_pkg::nib_vec_t quot,
    output icg_pkg::icg_side_t side_out
);
    import icg_pkg::*;

    logic            va_reg;
    prod_vec_t       rem_a_reg;
    prod_vec_t       rem_a_next;
    logic [1:0]      qa_reg   [CH_N];
    logic [1:0]      qa_next  [CH_N];
    cnt_t            div_a_reg;
    icg_side_t       side_a_reg;

    logic            vb_reg;
    nib_vec_t        q_b_reg;
    nib_vec_t        q_b_next;
    icg_side_t       side_b_reg;

    logic            a_en;
    logic            b_en;

    logic [PROD_W:0] t3 [CH_N];
    logic [PROD_W:0] t2 [CH_N];
    logic [PROD_W:0] t1 [CH_N];
    logic [PROD_W:0] t0 [CH_N];

    assign b_en     = !vb_reg || !out_stall;
    assign a_en     = !va_reg || b_en;
    assign in_stall = !a_en;

    // quotient bits 3 and 2
    always_comb
    begin
        for (int c = 0; c < CH_N; c++)
        begin
            t3[c]         = div_step(dividend[c], prod_t'({divisor, 3'b000}));
            t2[c]         = div_step(t3[c][PROD_W-1:0], prod_t'({divisor, 2'b00}));
            rem_a_next[c] = t2[c][PROD_W-1:0];
            qa_next[c]    = {t3[c][PROD_W], t2[c][PROD_W]};
        end
    end

    // quotient bits 1 and 0
    always_comb
    begin
        for (int c = 0; c < CH_N; c++)
        begin
            t1[c]       = div_step(rem_a_reg[c], prod_t'({div_a_reg, 1'b0}));
            t0[c]       = div_step(t1[c][PROD_W-1:0], prod_t'(div_a_reg));
            q_b_next[c] = {qa_reg[c], t1[c][PROD_W], t0[c][PROD_W]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            if (a_en)
            begin
                va_reg <= in_valid;
            end
            if (b_en)
            begin
                vb_reg <= va_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_en && in_valid)
        begin
            rem_a_reg  <= rem_a_next;
            qa_reg     <= qa_next;
            div_a_reg  <= divisor;
            side_a_reg <= side_in;
        end
        if (b_en && va_reg)
        begin
            q_b_reg    <= q_b_next;
            side_b_reg <= side_a_reg;
        end
    end

    assign out_valid = vb_reg;
    assign quot      = q_b_reg;
    assign side_out  = side_b_reg;

endmodule
